/* hdl/maf_pkg.sv */
// Shared constants, types and codes for the moving average filter.
`timescale 1ns / 1ps
package maf_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int PTR_W      = $clog2(WINDOW_MAX);
	localparam int CNT_W      = PTR_W + 1;
	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = SAMPLE_W + PTR_W;
	localparam int STEP_W     = $clog2(SUM_W + 1);
	localparam int WLEN_W     = 7;
	localparam int PADDR_W    = 3;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd8;
	localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(SUM_W);

	// Register index, taken from paddr[2]
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

/* hdl/maf_ctrl.sv */
// Controller state machine: sequences capture, sum update, division and output.
`timescale 1ns / 1ps
module maf_ctrl import maf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd,
	output state_t  state,
	output logic [STEP_W-1:0] step_cnt
);

	state_t state_q, state_next;
	logic [STEP_W-1:0] step_q;

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
			ST_UPDATE: state_next = ST_DIV;
			ST_DIV:    if (step_q == DIV_STEPS - STEP_W'(1)) state_next = ST_DONE;
			ST_DONE:   if (status.out_free) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_UPDATE: cmd.update = 1'b1;
			ST_DIV:    cmd.step   = 1'b1;
			ST_DONE:   cmd.finish = status.out_free;
			default:   cmd = '0;
		endcase
	end

	// Hold state and count divider steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_DIV) step_q <= step_q + STEP_W'(1);
			else step_q <= '0;
		end
	end

	assign state    = state_q;
	assign step_cnt = step_q;

endmodule

/* hdl/maf_datapath.sv */
// Datapath: delay line memory, running sum, restoring divider, output register.
`timescale 1ns / 1ps
module maf_datapath import maf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output status_t                    status,
	input  logic [WLEN_W-1:0]          window_length,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       block_start,
	output logic signed [SAMPLE_W-1:0] average,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [CNT_W-1:0]           seen
);

	logic signed [SAMPLE_W-1:0] mem [WINDOW_MAX];
	logic signed [SAMPLE_W-1:0] old_q, smp_q;
	logic                       bs_q;
	logic [PTR_W-1:0]           wp_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           seen_q;
	logic [CNT_W-1:0]           n;
	logic [CNT_W-1:0]           cnt_base, cnt_inc, div_next;
	logic                       grow;
	logic signed [SUM_W-1:0]    sum_base, sum_next;
	logic [CNT_W-1:0]           div_q;
	logic [CNT_W-1:0]           rem_q;
	logic [SUM_W-1:0]           quo_q;
	logic                       neg_q;
	logic [CNT_W:0]             trial;
	logic                       fits;
	logic signed [SAMPLE_W-1:0] avg_q, avg_next;
	logic                       out_valid_q;

	// Effective window length: zero acts as one, clamp to the delay line depth
	always_comb begin
		if (window_length == '0) n = CNT_W'(1);
		else if (window_length > WLEN_W'(WINDOW_MAX)) n = CNT_W'(WINDOW_MAX);
		else n = CNT_W'(window_length);
	end

	// Sum and count update
	always_comb begin
		cnt_base = bs_q ? '0 : seen_q;
		sum_base = bs_q ? '0 : sum_q;
		grow     = cnt_base < n;
		cnt_inc  = cnt_base + CNT_W'(1);
		if (grow) begin
			sum_next = sum_base + SUM_W'(smp_q);
			div_next = cnt_inc;
		end else begin
			sum_next = sum_base - SUM_W'(old_q) + SUM_W'(smp_q);
			div_next = n;
		end
	end

	// Delay line: read oldest slot on capture, write the new item on update
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			old_q <= mem[wp_q - n[PTR_W-1:0]];
			smp_q <= sample;
			bs_q  <= block_start;
		end
		if (cmd.update) mem[wp_q] <= smp_q;
	end

	// Running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			seen_q <= '0;
			wp_q   <= '0;
		end else if (cmd.update) begin
			sum_q  <= sum_next;
			seen_q <= grow ? cnt_inc : cnt_base;
			wp_q   <= wp_q + PTR_W'(1);
		end
	end

	// Restoring division of the sum magnitude, one quotient bit per cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			div_q <= div_next;
			rem_q <= '0;
			neg_q <= sum_next[SUM_W-1];
			quo_q <= sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
		end else if (cmd.step) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	// Apply sign and saturate to the sample range
	always_comb begin
		if (neg_q) begin
			if (quo_q > SUM_W'(2 ** (SAMPLE_W - 1)))
				avg_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
			else
				avg_next = SAMPLE_W'(-quo_q);
		end else begin
			if (quo_q > SUM_W'(2 ** (SAMPLE_W - 1) - 1))
				avg_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
			else
				avg_next = SAMPLE_W'(quo_q);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.finish) avg_q <= avg_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign average         = avg_q;
	assign out_valid       = out_valid_q;
	assign seen            = seen_q;

endmodule

/* hdl/moving_average_filter_top.sv */
// Top level: stream ports, configuration register, controller and datapath.
// An accepted input passes through the sum update, 22 divide steps and the output load before its result is valid.
// The next item is accepted only after the bit-serial restoring divider has finished with the previous one.
// A new item is accepted while the previous result still waits in the output register.
// Reset (arst_n, async, active low) clears sum, count, pointer and sets window length to 8.
// The delay line is not cleared; only entries written in the current block are read.
`timescale 1ns / 1ps
module moving_average_filter_top import maf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
	input  logic                s_tuser,   // [0] block_start
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] average
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [WLEN_W-1:0] wlen_q;
	cmd_t              cmd;
	status_t           status;
	state_t            state;
	logic [STEP_W-1:0] step_cnt;
	logic [CNT_W-1:0]  seen;
	logic signed [SAMPLE_W-1:0] average;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wlen_q <= WLEN_RESET;
		else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_LENGTH)
			wlen_q <= pwdata[WLEN_W-1:0];
	end

	assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? 32'(wlen_q) : '0;

	maf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd),
		.state    (state),
		.step_cnt (step_cnt)
	);

	maf_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.window_length (wlen_q),
		.sample        (s_tdata),
		.block_start   (s_tuser),
		.average       (average),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.seen          (seen)
	);

	assign m_tdata = average;

	// One item at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while previous item in flight");

	// Divider step count stays within the quotient width
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state == ST_DIV |-> step_cnt < DIV_STEPS)
		else $error("divider ran past its last step");

	// Sample count never exceeds the delay line depth
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen <= CNT_W'(WINDOW_MAX))
		else $error("sample count beyond window depth");

	// A result is loaded only when the output register can take it
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("result overwrote a pending output");

endmodule
